>>> hw/rtl/qsi_pkg.sv
// ----------------------------------------------------------------------------
// qsi_pkg
// Shared defaults and blend constants for the quintic setpoint interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package qsi_pkg;

   localparam int POS_BITS_DEF  = 12;
   localparam int STEP_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // polynomial r = t^3 (K10 - K15 t + K6 t^2)
   localparam int K10 = 10;
   localparam int K15 = 15;
   localparam int K6  = 6;

   // extra integer bits needed to hold the polynomial term p
   localparam int POLY_HEAD_BITS = 5;

endpackage : qsi_pkg

`default_nettype wire

>>> hw/rtl/quintic_setpoint_interpolator_core.sv
// Sequencing: a load is absorbed while idle with no response; a tick at or past the end
// of a move passes through the finish state to the output register; an interior tick
// runs the serial divider, four passes through the shared shift-add multiplier, the
// finish state and the output register. One transaction in flight: ready returns
// with the response, so a tick is not taken before the last response is registered.
// Synchronous reset: idle, start 0, goal mid, steps 0.
// ----------------------------------------------------------------------------
// quintic_setpoint_interpolator_core
// Minimum-jerk quintic setpoint generator for one axis, bit-serial datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_setpoint_interpolator_core #(
   parameter int POS_BITS  = qsi_pkg::POS_BITS_DEF,
   parameter int STEP_BITS = qsi_pkg::STEP_BITS_DEF,
   parameter int FRAC_BITS = qsi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_func,
   input  wire logic [POS_BITS-1:0]  req_start_pos,
   input  wire logic [POS_BITS-1:0]  req_goal_pos,
   input  wire logic [STEP_BITS-1:0] req_step_total,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [POS_BITS-1:0]       rsp_setpoint,
   output logic                      rsp_move_done
);

   import qsi_pkg::*;

   localparam int PW      = FRAC_BITS + POLY_HEAD_BITS;
   localparam int MA_BITS = (PW > POS_BITS) ? PW : POS_BITS;
   localparam int MB_BITS = FRAC_BITS + 1;
   localparam int PR_BITS = MA_BITS + MB_BITS;
   localparam int RH_BITS = PR_BITS - FRAC_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_T2     = 3'd2;
   localparam logic [2:0] ST_T3     = 3'd3;
   localparam logic [2:0] ST_R      = 3'd4;
   localparam logic [2:0] ST_POS    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   localparam logic [RH_BITS-1:0] FIX_ONE = RH_BITS'(1) << FRAC_BITS;

   logic [2:0]           state_ff, state_in;
   logic [POS_BITS-1:0]  start_ff, start_in;
   logic [POS_BITS-1:0]  goal_ff, goal_in;
   logic [STEP_BITS-1:0] steps_ff, steps_in;
   logic [STEP_BITS-1:0] step_now_ff, step_now_in;
   logic                 active_ff, active_in;

   logic [FRAC_BITS-1:0] t_ff, t_in;
   logic [FRAC_BITS-1:0] t2_ff, t2_in;

   logic [POS_BITS-1:0]  res_pos_ff, res_pos_in;
   logic                 res_done_ff, res_done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 accept;
   logic [STEP_BITS-1:0] step_next;
   logic                 div_start;
   logic                 div_done;
   logic [FRAC_BITS-1:0] quotient;
   logic                 mul_start;
   logic [MA_BITS-1:0]   mul_a;
   logic [MB_BITS-1:0]   mul_b;
   logic                 mul_done;
   logic [PR_BITS-1:0]   product;

   logic [PW-1:0]        p_pos;
   logic [PW-1:0]        p_neg;
   logic [PW-1:0]        poly;
   logic [RH_BITS-1:0]   r_raw;
   logic [FRAC_BITS:0]   r_val;
   logic [POS_BITS-1:0]  pos_span;
   logic [POS_BITS-1:0]  mag;
   logic                 rising;
   logic                 out_free;

   qsi_serial_div #(
      .NUM_BITS (STEP_BITS),
      .QUO_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (step_next),
      .den      (steps_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   qsi_serial_mul #(
      .A_BITS (MA_BITS),
      .B_BITS (MB_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (product)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign step_next = step_now_ff + STEP_BITS'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rising    = goal_ff >= start_ff;

   always_comb begin
      // p = 10 - 15 t + 6 t^2, clamped at zero
      p_pos = (PW'(K10) << FRAC_BITS) + PW'(K6) * PW'(t2_ff);
      p_neg = PW'(K15) * PW'(t_ff);
      poly  = (p_pos > p_neg) ? (p_pos - p_neg) : '0;

      r_raw = product[PR_BITS-1:FRAC_BITS];
      r_val = (r_raw > FIX_ONE) ? FIX_ONE[FRAC_BITS:0] : r_raw[FRAC_BITS:0];

      pos_span = rising ? (goal_ff - start_ff) : (start_ff - goal_ff);
      mag      = product[FRAC_BITS +: POS_BITS];
   end

   always_comb begin
      state_in    = state_ff;
      start_in    = start_ff;
      goal_in     = goal_ff;
      steps_in    = steps_ff;
      step_now_in = step_now_ff;
      active_in   = active_ff;
      t_in        = t_ff;
      t2_in       = t2_ff;
      res_pos_in  = res_pos_ff;
      res_done_in = res_done_ff;
      div_start   = 1'b0;
      mul_start   = 1'b0;
      mul_a       = MA_BITS'(t_ff);
      mul_b       = MB_BITS'(t_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  start_in    = req_start_pos;
                  goal_in     = req_goal_pos;
                  steps_in    = req_step_total;
                  step_now_in = '0;
                  active_in   = (req_step_total != '0);
               end else if (!active_ff || (step_now_ff >= steps_ff)) begin
                  active_in   = 1'b0;
                  res_pos_in  = goal_ff;
                  res_done_in = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  step_now_in = step_next;
                  if (step_next >= steps_ff) begin
                     active_in   = 1'b0;
                     res_pos_in  = goal_ff;
                     res_done_in = 1'b1;
                     state_in    = ST_FINISH;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_in      = quotient;
               mul_start = 1'b1;
               mul_a     = MA_BITS'(quotient);
               mul_b     = MB_BITS'(quotient);
               state_in  = ST_T2;
            end
         end
         ST_T2: begin
            if (mul_done) begin
               t2_in     = product[FRAC_BITS +: FRAC_BITS];
               mul_start = 1'b1;
               mul_a     = MA_BITS'(product[FRAC_BITS +: FRAC_BITS]);
               mul_b     = MB_BITS'(t_ff);
               state_in  = ST_T3;
            end
         end
         ST_T3: begin
            // product holds t^3 scaled; multiply by p next
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MA_BITS'(poly);
               mul_b     = MB_BITS'(product[FRAC_BITS +: FRAC_BITS]);
               state_in  = ST_R;
            end
         end
         ST_R: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MA_BITS'(pos_span);
               mul_b     = r_val;
               state_in  = ST_POS;
            end
         end
         ST_POS: begin
            if (mul_done) begin
               res_pos_in  = rising ? (start_ff + mag) : (start_ff - mag);
               res_done_in = 1'b0;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_done_in  = rsp_done_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = res_pos_ff;
         rsp_done_in  = res_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      res_pos_ff  <= res_pos_in;
      res_done_ff <= res_done_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_done_ff <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         goal_ff      <= POS_BITS'(1) << (POS_BITS - 1);
         steps_ff     <= '0;
         step_now_ff  <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         steps_ff     <= steps_in;
         step_now_ff  <= step_now_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_setpoint  = rsp_pos_ff;
   assign rsp_move_done = rsp_done_ff;

endmodule : quintic_setpoint_interpolator_core

`default_nettype wire

>>> hw/rtl/qsi_serial_div.sv
// ----------------------------------------------------------------------------
// qsi_serial_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^QUO_BITS / den)
// for num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module qsi_serial_div #(
   parameter int NUM_BITS = 16,
   parameter int QUO_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [NUM_BITS-1:0] den,
   output logic                     done,
   output logic [QUO_BITS-1:0]      quotient
);

   localparam int CNT_BITS = (QUO_BITS > 1) ? $clog2(QUO_BITS) : 1;

   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] den_ff, den_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [NUM_BITS:0] shifted;
   logic [NUM_BITS:0] diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};

      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below den, so it fits back in NUM_BITS
         rem_in = fits ? diff[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
         quo_in = {quo_ff[QUO_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : qsi_serial_div

`default_nettype wire

>>> hw/rtl/qsi_serial_mul.sv
// ----------------------------------------------------------------------------
// qsi_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module qsi_serial_mul #(
   parameter int A_BITS = 21,
   parameter int B_BITS = 17
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [A_BITS-1:0]        mcand,
   input  wire logic [B_BITS-1:0]        mplier,
   output logic                          done,
   output logic [A_BITS+B_BITS-1:0]      product
);

   localparam int CNT_BITS = $clog2(B_BITS);

   logic [A_BITS-1:0]        mcand_ff, mcand_in;
   logic [A_BITS+B_BITS-1:0] prod_ff, prod_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [A_BITS:0] sum;

   always_comb begin
      // upper half accumulates, lower half holds the unused multiplier bits
      sum = {1'b0, prod_ff[A_BITS+B_BITS-1:B_BITS]}
          + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (start) begin
         mcand_in = mcand;
         prod_in  = {{A_BITS{1'b0}}, mplier};
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[B_BITS-1:1]};
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(B_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule : qsi_serial_mul

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quintic setpoint interpolator core. A directed
// table, then random move sequences under four idle/stall mixes; every tick response
// is checked against a local minimum-jerk setpoint predictor or a typed table value.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W  = qsi_pkg::POS_BITS_DEF;
   localparam int STEP_W = qsi_pkg::STEP_BITS_DEF;
   localparam int FRAC_W = qsi_pkg::FRAC_BITS_DEF;

   localparam logic FUNC_LOAD = qsi_pkg::FUNC_LOAD;
   localparam logic FUNC_TICK = qsi_pkg::FUNC_TICK;

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [POS_W-1:0]  POS_MID  = POS_W'(1) << (POS_W - 1);
   localparam logic [STEP_W-1:0] STEP_MAX = '1;
   localparam longint unsigned   UNIT     = 64'd1 << FRAC_W;

   localparam int SHOW_LIMIT  = 10;
   localparam int DRAIN_WAIT  = 200;

   typedef struct packed {
      logic [POS_W-1:0] setpoint;
      logic             done;
   } setpoint_type;

   typedef struct {
      logic              func;
      logic [POS_W-1:0]  start_pos;
      logic [POS_W-1:0]  goal_pos;
      logic [STEP_W-1:0] step_total;
      bit                typed;
      setpoint_type      want;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_func = FUNC_LOAD;
   logic [POS_W-1:0]  req_start_pos = '0;
   logic [POS_W-1:0]  req_goal_pos = '0;
   logic [STEP_W-1:0] req_step_total = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [POS_W-1:0]  rsp_setpoint;
   logic              rsp_move_done;

   quintic_setpoint_interpolator_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_start_pos  (req_start_pos),
      .req_goal_pos   (req_goal_pos),
      .req_step_total (req_step_total),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_setpoint   (rsp_setpoint),
      .rsp_move_done  (rsp_move_done)
   );

   always #6 clock = ~clock;

   // predictor copy of the axis state
   logic [POS_W-1:0]  trk_start = '0;
   logic [POS_W-1:0]  trk_goal  = POS_MID;
   logic [STEP_W-1:0] trk_len   = '0;
   logic [STEP_W-1:0] trk_step  = '0;
   bit                trk_live  = 1'b0;

   setpoint_type  setpoint_queue [$];
   table_row_type dir_rows [$];
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          fail_count = 0;
   int          loads_sent = 0;
   int          ticks_sent = 0;
   int          checked    = 0;
   int          done_seen  = 0;

   // minimum-jerk fraction r(s/n) in Q1.FRAC_W, truncating at every stage
   function automatic longint unsigned minjerk_fraction(longint unsigned s,
                                                        longint unsigned n);
      longint unsigned t, t2, t3, poly, r;
      if (n == 0) return UNIT;
      t = (s << FRAC_W) / n;
      if (t > UNIT) t = UNIT;
      t2 = (t * t) >> FRAC_W;
      t3 = (t2 * t) >> FRAC_W;
      poly = qsi_pkg::K10 * UNIT + qsi_pkg::K6 * t2;
      poly = (poly > qsi_pkg::K15 * t) ? poly - qsi_pkg::K15 * t : 0;
      r = (t3 * poly) >> FRAC_W;
      if (r > UNIT) r = UNIT;
      return r;
   endfunction

   function automatic logic [POS_W-1:0] setpoint_between(logic [POS_W-1:0] a,
                                                         logic [POS_W-1:0] b,
                                                         longint unsigned r);
      longint unsigned span;
      if (b >= a) begin
         span = ((longint'(b) - longint'(a)) * r) >> FRAC_W;
         return a + span[POS_W-1:0];
      end
      span = ((longint'(a) - longint'(b)) * r) >> FRAC_W;
      return a - span[POS_W-1:0];
   endfunction

   // advances the predicted axis by one transaction; 1 when a response follows
   function automatic bit predict_setpoint(logic f, logic [POS_W-1:0] s,
                                           logic [POS_W-1:0] g,
                                           logic [STEP_W-1:0] n,
                                           output setpoint_type res);
      res = '0;
      if (f == FUNC_LOAD) begin
         trk_start = s;
         trk_goal  = g;
         trk_len   = n;
         trk_step  = '0;
         trk_live  = (n != 0);
         return 1'b0;
      end
      if (!trk_live || trk_step >= trk_len) begin
         trk_live = 1'b0;
         res = '{trk_goal, 1'b1};
         return 1'b1;
      end
      trk_step = trk_step + STEP_W'(1);
      if (trk_step >= trk_len) begin
         trk_live = 1'b0;
         res = '{trk_goal, 1'b1};
         return 1'b1;
      end
      res = '{setpoint_between(trk_start, trk_goal,
                               minjerk_fraction(trk_step, trk_len)), 1'b0};
      return 1'b1;
   endfunction

   task automatic note_failure(string what, setpoint_type want, setpoint_type got);
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
         $display("%0t MISMATCH %s: expected setpoint %0d done %0b, got setpoint %0d done %0b",
                  $realtime, what, want.setpoint, want.done, got.setpoint, got.done);
   endtask

   // one transaction on the request side; typed rows override the predictor
   task automatic send_item(logic f, logic [POS_W-1:0] s, logic [POS_W-1:0] g,
                            logic [STEP_W-1:0] n, bit typed = 1'b0,
                            setpoint_type want = '0);
      setpoint_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_start_pos  <= s;
      req_goal_pos   <= g;
      req_step_total <= n;
      do @(posedge clock); while (!req_ready);
      if (predict_setpoint(f, s, g, n, pred))
         setpoint_queue.push_back(typed ? want : pred);
      if (f == FUNC_LOAD) loads_sent++;
      else ticks_sent++;
   endtask

   function automatic logic [POS_W-1:0] pick_pos();
      case ($urandom_range(7))
         0: return '0;
         1: return POS_MAX;
         default: return POS_W'($urandom());
      endcase
   endfunction

   task automatic tick_times(int count);
      repeat (count) send_item(FUNC_TICK, POS_W'($urandom()), POS_W'($urandom()),
                               STEP_W'($urandom()));
   endtask

   // random move sequences, mostly complete moves with random endpoints
   task automatic run_moves(int budget);
      int sent, kind, len, ticks;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(24) : $urandom_range(8);
            ticks = len + $urandom_range(2);
            send_item(FUNC_LOAD, pick_pos(), pick_pos(), STEP_W'(len));
         end else if (kind < 82) begin
            // long move, dropped by the next load
            ticks = $urandom_range(6, 1);
            send_item(FUNC_LOAD, pick_pos(), pick_pos(), STEP_W'($urandom()));
         end else if (kind < 92) begin
            len = $urandom_range(12, 2);
            ticks = $urandom_range(len - 1);
            send_item(FUNC_LOAD, pick_pos(), pick_pos(), STEP_W'(len));
         end else begin
            ticks = $urandom_range(3, 1);
            sent--;
         end
         tick_times(ticks);
         sent += ticks + 1;
      end
   endtask

   function automatic void add_row(logic f, logic [POS_W-1:0] s, logic [POS_W-1:0] g,
                                   logic [STEP_W-1:0] n, bit typed = 1'b0,
                                   logic [POS_W-1:0] sp = '0, logic dn = 1'b0);
      table_row_type row;
      row.func = f;
      row.start_pos = s;
      row.goal_pos = g;
      row.step_total = n;
      row.typed = typed;
      row.want = '{sp, dn};
      dir_rows.push_back(row);
   endfunction

   // response side: random stalls, checks against the oldest expectation
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      setpoint_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_setpoint, rsp_move_done};
         if (setpoint_queue.size() == 0) begin
            note_failure("response with nothing outstanding", '0, got);
         end else begin
            want = setpoint_queue.pop_front();
            checked++;
            if (got.done) done_seen++;
            if (got.setpoint !== want.setpoint) note_failure("setpoint", want, got);
            else if (got.done !== want.done) note_failure("move_done", want, got);
         end
      end
   end

   initial begin
      #12_000_000;
      $display("Timeout with %0d responses outstanding", setpoint_queue.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      // tick after reset, zero step total, idle ticks, one-step move
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, POS_MID, 1'b1);
      add_row(FUNC_LOAD, '0, POS_MAX, '0);
      add_row(FUNC_TICK, POS_MAX, '0, STEP_MAX, 1'b1, POS_MAX, 1'b1);
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, POS_MAX, 1'b1);
      add_row(FUNC_LOAD, '0, POS_MAX, STEP_W'(1));
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, POS_MAX, 1'b1);
      // downward full-scale move, then a tick past the end
      add_row(FUNC_LOAD, POS_MAX, '0, STEP_W'(4));
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, '0, 1'b1);
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, '0, 1'b1);
      // longest move, dropped by a load mid-move
      add_row(FUNC_LOAD, '0, POS_MAX, STEP_MAX);
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_LOAD, POS_MID, POS_MID, STEP_W'(2));
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, POS_MID, 1'b1);
      // start equals goal at the top, then an ordinary move
      add_row(FUNC_LOAD, POS_MAX, POS_MAX, STEP_W'(3));
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0);
      add_row(FUNC_TICK, '0, '0, '0, 1'b1, POS_MAX, 1'b1);
      add_row(FUNC_LOAD, POS_W'(1234), POS_W'(3001), STEP_W'(5));
      tick_rows: for (int k = 0; k < 5; k++) add_row(FUNC_TICK, '0, '0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].func, dir_rows[i].start_pos, dir_rows[i].goal_pos,
                   dir_rows[i].step_total, dir_rows[i].typed, dir_rows[i].want);

      send_idle_pct = 0;  recv_stall_pct = 0;  run_moves(330);
      send_idle_pct = 62; recv_stall_pct = 0;  run_moves(330);
      send_idle_pct = 0;  recv_stall_pct = 62; run_moves(330);
      send_idle_pct = 35; recv_stall_pct = 35; run_moves(330);

      @(negedge clock);
      req_valid <= 1'b0;
      while (setpoint_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d move loads and %0d ticks; %0d responses checked, %0d ending a move",
               loads_sent, ticks_sent, checked, done_seen);
      $display("Mismatches: %0d", fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : testbench
